// ----- src/epoch_seconds_to_calendar_top_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the epoch to calendar converter
// Shared property forms, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef EPOCH_SECONDS_TO_CALENDAR_TOP_ASSERT_SVH
`define EPOCH_SECONDS_TO_CALENDAR_TOP_ASSERT_SVH

// Condition that must hold at every edge out of reset
`define ESC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that must hold in the same cycle as the antecedent
`define ESC_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/esc_pkg.sv -----
// ----------------------------------------------------------------------------
// esc_pkg
// Constants, types and the month start table for the epoch to calendar block.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

    localparam int unsigned SECS_PER_DAY   = 86400;
    localparam int unsigned LOW_SHIFT      = 7;
    localparam int unsigned DAY_DIV        = SECS_PER_DAY >> LOW_SHIFT;
    localparam int unsigned SECS_PER_MIN   = 60;
    localparam int unsigned MINS_PER_HOUR  = 60;

    localparam int unsigned DAYS_TO_MARCH_ZERO = 719468;
    localparam int unsigned DAYS_PER_ERA       = 146097;
    // A 32-bit count of seconds only reaches eras four and five
    localparam int unsigned ERA_LO             = 4;
    localparam int unsigned ERA_SPLIT          = (ERA_LO + 1) * DAYS_PER_ERA
                                                 - DAYS_TO_MARCH_ZERO;
    localparam int unsigned ERA_LO_OFFSET      = DAYS_TO_MARCH_ZERO - ERA_LO * DAYS_PER_ERA;
    localparam int unsigned YEAR_BASE_LO       = ERA_LO * 400;
    localparam int unsigned YEAR_BASE_HI       = (ERA_LO + 1) * 400;

    localparam int unsigned DAYS_4Y        = 1460;
    localparam int unsigned DAYS_100Y      = 36524;
    localparam int unsigned DAYS_400Y_LAST = 146096;
    localparam int unsigned DAYS_PER_YEAR  = 365;
    localparam int unsigned MONTH_SPAN     = 153;

    localparam logic [3:0] MONTH_FEB        = 4'd2;
    localparam logic [3:0] MP_JAN           = 4'd10;

    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } hms_t;

    // First day of the month within a March-based year, (153 * mp + 2) / 5
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] start;
        case (mp)
            4'd0:    start = 9'd0;
            4'd1:    start = 9'd31;
            4'd2:    start = 9'd61;
            4'd3:    start = 9'd92;
            4'd4:    start = 9'd122;
            4'd5:    start = 9'd153;
            4'd6:    start = 9'd184;
            4'd7:    start = 9'd214;
            4'd8:    start = 9'd245;
            4'd9:    start = 9'd275;
            4'd10:   start = 9'd306;
            4'd11:   start = 9'd337;
            default: start = 9'd0;
        endcase
        return start;
    endfunction

endpackage

`default_nettype wire

// ----- src/esc_const_div.sv -----
// ----------------------------------------------------------------------------
// esc_const_div
// Two-stage division by a constant: reciprocal multiply, then one correction.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_const_div #(
    parameter int W  = 17,
    parameter int D  = 60,
    parameter int QW = 11
) (
    input  wire logic                  clk,
    input  wire logic                  en_mul,
    input  wire logic                  en_cor,
    input  wire logic [W-1:0]          x,
    output logic      [QW-1:0]         q,
    output logic      [$clog2(D)-1:0]  r
);

    localparam int RW = $clog2(D);
    localparam longint unsigned MAGIC = (64'd1 << W) / 64'(D);
    localparam logic [W-1:0] MC = W'(MAGIC);
    localparam logic [W-1:0] DC = W'(D);

    logic [W-1:0]    x_reg;
    logic [2*W-1:0]  prod_reg;
    logic [QW-1:0]   q_reg;
    logic [RW-1:0]   r_reg;

    logic [W-1:0]    q0;
    logic [W-1:0]    r0;
    logic            fix;
    logic [W-1:0]    q_next;
    logic [W-1:0]    r_next;

    // Estimate is low by at most one since x < 2**W
    always_ff @(posedge clk)
    begin
        if (en_mul)
        begin
            x_reg    <= x;
            prod_reg <= (2*W)'(x) * (2*W)'(MC);
        end
        if (en_cor)
        begin
            q_reg <= q_next[QW-1:0];
            r_reg <= r_next[RW-1:0];
        end
    end

    always_comb
    begin
        q0     = prod_reg[2*W-1:W];
        r0     = x_reg - q0 * DC;
        fix    = (r0 >= DC);
        q_next = fix ? q0 + W'(1) : q0;
        r_next = fix ? r0 - DC : r0;
    end

    assign q = q_reg;
    assign r = r_reg;

endmodule

`default_nettype wire

// ----- src/epoch_seconds_to_calendar_top.sv -----
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_top
// Converts seconds since 1970-01-01 00:00 UTC into Gregorian date and time.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall carries one request: epoch_seconds.
//   Output channel out_valid / out_stall carries the calendar fields of that
//   request: cal_year, cal_month, cal_day, hour_of_day, minute_of_hour and
//   second_of_minute. A request moves at an edge with valid high, stall low.
//   Throughput while the output is not stalled is
//   one request per cycle. Each stage holds a valid bit and advances whenever
//   it is empty or the stage after it advances, so a stall on the output only
//   backs up as far as there are full stages; bubbles still fill behind it.
//   in_stall rises only once all 12 stages hold a request under a stall.
//   Reset clears every valid bit; payload registers keep whatever they hold.
//   Each constant divider is a registered
//   reciprocal multiply followed by a registered back-multiply by the
//   constant with a single subtract-and-compare correction.
//   The block has no state between requests and no configuration.
// ----------------------------------------------------------------------------
`default_nettype none

`include "epoch_seconds_to_calendar_top_assert.svh"

module epoch_seconds_to_calendar_top
    import esc_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [31:0] epoch_seconds,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [11:0] cal_year,
    output logic      [3:0]  cal_month,
    output logic      [4:0]  cal_day,
    output logic      [4:0]  hour_of_day,
    output logic      [5:0]  minute_of_hour,
    output logic      [5:0]  second_of_minute
);

    localparam int NS = 12;

    // ---------------------------------------------------------------- control
    logic [NS:1]   v_reg;
    logic [NS+1:1] adv;

    // Advance a stage when it is empty or its successor advances
    always_comb
    begin
        adv[NS+1] = !out_stall;
        for (int k = NS; k >= 1; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[1])
            begin
                v_reg[1] <= in_valid;
            end
            for (int k = 2; k <= NS; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign in_stall  = !adv[1];
    assign out_valid = v_reg[NS];

    // ------------------------------------------------- stages 1-2: day count
    // t / 86400 = (t >> 7) / 675; the low seven bits rejoin the remainder
    logic [15:0] days2;
    logic [9:0]  day_rem2;
    logic [6:0]  tlo1_reg;
    logic [6:0]  tlo2_reg;
    logic [16:0] sod2;

    esc_const_div #(.W(32 - LOW_SHIFT), .D(DAY_DIV), .QW(16)) u_div_day (
        .clk    (clk),
        .en_mul (adv[1]),
        .en_cor (adv[2]),
        .x      (epoch_seconds[31:LOW_SHIFT]),
        .q      (days2),
        .r      (day_rem2)
    );

    always_ff @(posedge clk)
    begin
        if (adv[1]) tlo1_reg <= epoch_seconds[LOW_SHIFT-1:0];
        if (adv[2]) tlo2_reg <= tlo1_reg;
    end

    assign sod2 = {day_rem2, tlo2_reg};

    // ------------------------------------------------ time of day, stages 3-6
    logic [10:0] mtot4;
    logic [5:0]  sec4;
    logic [5:0]  sec5_reg;
    logic [5:0]  sec6_reg;
    logic [4:0]  hour6;
    logic [5:0]  min6;
    hms_t        hms6;
    hms_t        hms_reg [7:NS];

    esc_const_div #(.W(17), .D(SECS_PER_MIN), .QW(11)) u_div_min (
        .clk    (clk),
        .en_mul (adv[3]),
        .en_cor (adv[4]),
        .x      (sod2),
        .q      (mtot4),
        .r      (sec4)
    );

    esc_const_div #(.W(11), .D(MINS_PER_HOUR), .QW(5)) u_div_hour (
        .clk    (clk),
        .en_mul (adv[5]),
        .en_cor (adv[6]),
        .x      (mtot4),
        .q      (hour6),
        .r      (min6)
    );

    assign hms6 = '{hour: hour6, minute: min6, second: sec6_reg};

    // Hold the time fields alongside the date until the output stage
    always_ff @(posedge clk)
    begin
        if (adv[5]) sec5_reg <= sec4;
        if (adv[6]) sec6_reg <= sec5_reg;
        if (adv[7]) hms_reg[7] <= hms6;
        for (int k = 8; k <= NS; k++)
        begin
            if (adv[k]) hms_reg[k] <= hms_reg[k-1];
        end
    end

    // ------------------------------------------------------ date, stages 3-12
    logic [17:0] doe3_reg, doe4_reg, doe5_reg, doe6_reg, doe7_reg, doe8_reg;
    logic        era3_reg, era4_reg, era5_reg, era6_reg, era7_reg, era8_reg;
    logic        era9_reg, era10_reg, era11_reg;
    logic [2:0]  cent4_reg, cent5_reg;
    logic        last4_reg, last5_reg;
    logic [6:0]  quad5;
    logic [17:0] n6_reg;
    logic [8:0]  yoe8;
    logic [8:0]  yoe9_reg, yoe10_reg, yoe11_reg;
    logic [8:0]  doy9_reg, doy10_reg, doy11_reg;
    logic [3:0]  mp11;

    logic        era_hi;
    logic [17:0] doe_next;
    logic [2:0]  cent_next;
    logic [17:0] n_next;
    logic [1:0]  yoe_cent;
    logic [17:0] yoe_days;
    logic [17:0] doy_next;
    logic [10:0] mp_num;

    always_comb
    begin
        // Era index from a single threshold on the day count
        era_hi   = (days2 >= 16'(ERA_SPLIT));
        doe_next = era_hi ? 18'(days2) - 18'(ERA_SPLIT)
                          : 18'(days2) + 18'(ERA_LO_OFFSET);

        cent_next = 3'(doe3_reg >= 18'(DAYS_100Y))
                  + 3'(doe3_reg >= 18'(2 * DAYS_100Y))
                  + 3'(doe3_reg >= 18'(3 * DAYS_100Y))
                  + 3'(doe3_reg >= 18'(4 * DAYS_100Y));

        n_next = doe5_reg - 18'(quad5) + 18'(cent5_reg) - 18'(last5_reg);

        yoe_cent = 2'(yoe8 >= 9'd100) + 2'(yoe8 >= 9'd200) + 2'(yoe8 >= 9'd300);
        yoe_days = 18'(yoe8) * 18'(DAYS_PER_YEAR) + 18'(yoe8[8:2]) - 18'(yoe_cent);
        doy_next = doe8_reg - yoe_days;

        mp_num = 11'(doy9_reg) * 11'd5 + 11'd2;
    end

    esc_const_div #(.W(18), .D(DAYS_4Y), .QW(7)) u_div_quad (
        .clk    (clk),
        .en_mul (adv[4]),
        .en_cor (adv[5]),
        .x      (doe3_reg),
        .q      (quad5),
        .r      ()
    );

    esc_const_div #(.W(18), .D(DAYS_PER_YEAR), .QW(9)) u_div_year (
        .clk    (clk),
        .en_mul (adv[7]),
        .en_cor (adv[8]),
        .x      (n6_reg),
        .q      (yoe8),
        .r      ()
    );

    esc_const_div #(.W(11), .D(MONTH_SPAN), .QW(4)) u_div_month (
        .clk    (clk),
        .en_mul (adv[10]),
        .en_cor (adv[11]),
        .x      (mp_num),
        .q      (mp11),
        .r      ()
    );

    always_ff @(posedge clk)
    begin
        if (adv[3])
        begin
            doe3_reg <= doe_next;
            era3_reg <= era_hi;
        end
        if (adv[4])
        begin
            doe4_reg  <= doe3_reg;
            era4_reg  <= era3_reg;
            cent4_reg <= cent_next;
            last4_reg <= (doe3_reg >= 18'(DAYS_400Y_LAST));
        end
        if (adv[5])
        begin
            doe5_reg  <= doe4_reg;
            era5_reg  <= era4_reg;
            cent5_reg <= cent4_reg;
            last5_reg <= last4_reg;
        end
        if (adv[6])
        begin
            n6_reg   <= n_next;
            doe6_reg <= doe5_reg;
            era6_reg <= era5_reg;
        end
        if (adv[7])
        begin
            doe7_reg <= doe6_reg;
            era7_reg <= era6_reg;
        end
        if (adv[8])
        begin
            doe8_reg <= doe7_reg;
            era8_reg <= era7_reg;
        end
        if (adv[9])
        begin
            doy9_reg <= doy_next[8:0];
            yoe9_reg <= yoe8;
            era9_reg <= era8_reg;
        end
        if (adv[10])
        begin
            doy10_reg <= doy9_reg;
            yoe10_reg <= yoe9_reg;
            era10_reg <= era9_reg;
        end
        if (adv[11])
        begin
            doy11_reg <= doy10_reg;
            yoe11_reg <= yoe10_reg;
            era11_reg <= era10_reg;
        end
    end

    // ----------------------------------------------------- stage 12: output
    logic [11:0] cal_year_reg,  cal_year_next;
    logic [3:0]  cal_month_reg, cal_month_next;
    logic [4:0]  cal_day_reg;
    logic [8:0]  day_next;

    // Drop back from the March-based year to January-based months
    always_comb
    begin
        day_next       = doy11_reg - month_start(mp11) + 9'd1;
        cal_month_next = (mp11 < MP_JAN) ? mp11 + 4'd3 : mp11 - 4'd9;
        cal_year_next  = 12'(yoe11_reg)
                       + (era11_reg ? 12'(YEAR_BASE_HI) : 12'(YEAR_BASE_LO))
                       + 12'(cal_month_next <= MONTH_FEB);
    end

    always_ff @(posedge clk)
    begin
        if (adv[12])
        begin
            cal_year_reg  <= cal_year_next;
            cal_month_reg <= cal_month_next;
            cal_day_reg   <= day_next[4:0];
        end
    end

    assign cal_year         = cal_year_reg;
    assign cal_month        = cal_month_reg;
    assign cal_day          = cal_day_reg;
    assign hour_of_day      = hms_reg[NS].hour;
    assign minute_of_hour   = hms_reg[NS].minute;
    assign second_of_minute = hms_reg[NS].second;

    // ------------------------------------------------------------ assertions
    `ESC_ASSERT_IMPLY(a_no_backpressure, !out_stall, !in_stall,
        "stall without output stall")
    `ESC_ASSERT_IMPLY(a_date_fields, out_valid,
        cal_month >= 4'd1 && cal_month <= 4'd12 && cal_day >= 5'd1 && cal_day <= 5'd31,
        "date field out of range")
    `ESC_ASSERT_IMPLY(a_time_fields, out_valid,
        hour_of_day < 5'd24 && minute_of_hour < 6'd60 && second_of_minute < 6'd60,
        "time field out of range")
    `ESC_ASSERT_IMPLY(a_year_span, out_valid,
        cal_year >= 12'd1970 && cal_year <= 12'd2106,
        "year out of range")

endmodule

`default_nettype wire

// ----- tb/tb_epoch_seconds_to_calendar_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_epoch_seconds_to_calendar_top
// Self-checking bench for the seconds-to-calendar converter. A directed table
// covers the range ends, day, month, year and leap boundaries. About a
// thousand random requests follow, under several patterns of sender gaps and
// receiver stalls. An independent predictor works out each date and time of
// day not in the table; each result is compared field by field in arrival order.
// ----------------------------------------------------------------------------

module tb_epoch_seconds_to_calendar_top;

    // Time and calendar constants used by the predictor
    localparam int unsigned DAY_SECONDS    = 86400;
    localparam int unsigned HOUR_SECONDS   = 3600;
    localparam int unsigned MARCH_ZERO_DAY = 719468;
    localparam int unsigned ERA_DAYS       = 146097;

    // Run shape
    localparam int DIRECTED_ROWS   = 25;
    localparam int PHASE_REQUESTS  = 250;
    localparam int BURST_REQUESTS  = 50;
    localparam int LONG_HOLD       = 300;
    localparam int DRAIN_CYCLES    = 30;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int REPORT_LIMIT    = 10;

    // One calendar result, laid out as the output ports are
    typedef struct packed {
        logic [11:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } cal_rec_t;

    // One row of the directed table; the date is only used when typed_in is set
    typedef struct packed {
        logic [31:0] secs;
        logic        typed_in;
        cal_rec_t    want;
    } stim_row_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic [31:0] epoch_seconds  = '0;
    logic        out_stall      = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [11:0] cal_year;
    logic [3:0]  cal_month;
    logic [4:0]  cal_day;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;

    // Dates still owed by the converter, oldest first
    cal_rec_t pending_dates [$];

    int  send_idle_pct   = 0;
    int  stall_pct       = 0;
    bit  hold_wanted     = 1'b0;
    int  cycle_count     = 0;
    int  requests_sent   = 0;
    int  dates_checked   = 0;
    int  mismatch_count  = 0;
    int  input_backed_up = 0;

    // Directed table: range ends, day, month and year turns, leap days in
    // 2000 and 2004, the missing leap day of 2100, the 2038 signed wrap point
    // and alternating bit patterns
    stim_row_t directed_rows [0:DIRECTED_ROWS-1] = '{
        '{32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{32'd59,         1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd59}},
        '{32'd3599,       1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd59, 6'd59}},
        '{32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
        '{32'd86400,      1'b1, '{12'd1970, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0}},
        '{32'd31535999,   1'b1, '{12'd1970, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
        '{32'd31536000,   1'b1, '{12'd1971, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{32'd946684799,  1'b0, '0},
        '{32'd946684800,  1'b1, '{12'd2000, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
        '{32'd951782400,  1'b1, '{12'd2000, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0}},
        '{32'd951868800,  1'b0, '0},
        '{32'd1072915199, 1'b0, '0},
        '{32'd1078012800, 1'b0, '0},
        '{32'd2147483647, 1'b0, '0},
        '{32'd2147483648, 1'b0, '0},
        '{32'd4102444799, 1'b0, '0},
        '{32'd4102444800, 1'b0, '0},
        '{32'd4107542399, 1'b0, '0},
        '{32'd4107542400, 1'b0, '0},
        '{32'd4294944000, 1'b0, '0},
        '{32'hFFFF_FFFF,  1'b1, '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15}},
        '{32'h5555_5555,  1'b0, '0},
        '{32'hAAAA_AAAA,  1'b0, '0},
        '{32'h0000_FFFF,  1'b0, '0},
        '{32'hFFFF_0000,  1'b0, '0}
    };

    epoch_seconds_to_calendar_top uut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .epoch_seconds    (epoch_seconds),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .cal_year         (cal_year),
        .cal_month        (cal_month),
        .cal_day          (cal_day),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Calendar date and time of day for a count of seconds since 1970.
    // Shift the day count to a March-based epoch at year zero, split it into
    // 400-year eras, then into years and months of that era.
    function automatic cal_rec_t calendar_of(input logic [31:0] secs);
        int unsigned secs_in_day, shifted_days, era_idx, day_of_era;
        int unsigned year_of_era, day_of_year, month_idx, month_num, year_num;
        cal_rec_t    rec;
        secs_in_day  = secs % DAY_SECONDS;
        shifted_days = secs / DAY_SECONDS + MARCH_ZERO_DAY;
        era_idx      = shifted_days / ERA_DAYS;
        day_of_era   = shifted_days - era_idx * ERA_DAYS;
        year_of_era  = (day_of_era - day_of_era / 1460 + day_of_era / 36524
                        - day_of_era / 146096) / 365;
        day_of_year  = day_of_era - (365 * year_of_era + year_of_era / 4
                                     - year_of_era / 100);
        month_idx    = (5 * day_of_year + 2) / 153;
        month_num    = (month_idx < 10) ? month_idx + 3 : month_idx - 9;
        // January and February belong to the following civil year
        year_num     = year_of_era + era_idx * 400 + ((month_num <= 2) ? 1 : 0);
        rec.year     = year_num[11:0];
        rec.month    = month_num[3:0];
        rec.day      = 5'(day_of_year - (153 * month_idx + 2) / 5 + 1);
        rec.hour     = 5'(secs_in_day / HOUR_SECONDS);
        rec.minute   = 6'((secs_in_day / 60) % 60);
        rec.second   = 6'(secs_in_day % 60);
        return rec;
    endfunction

    // Random timestamp: half uniform over the whole range, the rest aimed at
    // midnight turns and at the last hours before the range runs out
    function automatic logic [31:0] random_seconds();
        logic [63:0] wide;
        case ($urandom_range(0, 3))
            2:
            begin
                wide = 64'($urandom_range(0, 49710)) * DAY_SECONDS;
                case ($urandom_range(0, 2))
                    0:       wide = wide;
                    1:       wide = wide + DAY_SECONDS - 1;
                    default: wide = wide + $urandom_range(0, DAY_SECONDS - 1);
                endcase
                if (wide > 64'hFFFF_FFFF)
                    wide = 64'hFFFF_FFFF;
                return wide[31:0];
            end
            3:       return 32'hFFFF_FFFF - $urandom_range(0, 200000);
            default: return $urandom();
        endcase
    endfunction

    // Offer one request, after a random idle gap, and hold it until it is taken.
    // Sample the handshake straight after the edge, before any update lands.
    task automatic send_request(input logic [31:0] secs, input cal_rec_t want,
                                input bit use_want);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        epoch_seconds <= secs;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        pending_dates.push_back(use_want ? want : calendar_of(secs));
        requests_sent++;
    endtask

    // Pause the sender until every owed date has come back
    task automatic wait_for_drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_dates.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: stall at the current rate, or hold off for a long stretch
    // when asked, counting that stretch here
    initial
    begin : receiver
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_wanted && hold_left == 0)
            begin
                hold_wanted = 1'b0;
                hold_left   = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Checker: compare each delivered date with the oldest one owed
    always @(posedge clk)
    begin
        cal_rec_t got, owed;
        if (rst_n && in_valid && in_stall)
            input_backed_up++;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{cal_year, cal_month, cal_day, hour_of_day, minute_of_hour,
                    second_of_minute};
            if (pending_dates.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("[%0t] unexpected result %0d-%0d-%0d %0d:%0d:%0d",
                             $realtime, got.year, got.month, got.day, got.hour,
                             got.minute, got.second);
            end
            else
            begin
                owed = pending_dates.pop_front();
                dates_checked++;
                if (got.year !== owed.year || got.month !== owed.month
                    || got.day !== owed.day || got.hour !== owed.hour
                    || got.minute !== owed.minute || got.second !== owed.second)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display({"[%0t] date mismatch: expected %0d-%0d-%0d ",
                                  "%0d:%0d:%0d, got %0d-%0d-%0d %0d:%0d:%0d"},
                                 $realtime, owed.year, owed.month, owed.day,
                                 owed.hour, owed.minute, owed.second, got.year,
                                 got.month, got.day, got.hour, got.minute,
                                 got.second);
                end
            end
        end
    end

    // Watchdog: end the run if it hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d dates still owed",
                     cycle_count, pending_dates.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin : stimulus
        int send_pct_by_phase  [0:3] = '{0, 48, 0, 6};
        int stall_pct_by_phase [0:3] = '{0, 0, 48, 6};
        // Hold reset low, then release it on an edge
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the directed table back to back
        for (int row = 0; row < DIRECTED_ROWS; row++)
            send_request(directed_rows[row].secs, directed_rows[row].want,
                         directed_rows[row].typed_in);
        wait_for_drain();

        // Random phases: free flow, sender gaps, receiver stalls, light mix
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct = send_pct_by_phase[phase];
            stall_pct     = stall_pct_by_phase[phase];
            for (int n = 0; n < PHASE_REQUESTS; n++)
                send_request(random_seconds(), '0, 1'b0);

            if (phase == 0)
            begin
                // Hold the receiver off and keep offering requests, so the
                // pipeline fills and the input backs up; then drain it fully
                hold_wanted = 1'b1;
                for (int n = 0; n < BURST_REQUESTS; n++)
                    send_request(random_seconds(), '0, 1'b0);
            end
            wait_for_drain();
        end

        // Let any stray result show itself past the pipeline depth
        stall_pct = 0;
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests (%0d dates checked), range ends, leap days,",
                 requests_sent, dates_checked);
        $display("gaps, stalls and a full back-up (%0d cycles with input held off)",
                 input_backed_up);
        if (mismatch_count == 0 && pending_dates.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
